// ===== src/assert_macros.svh =====
// Assertion macros shared by the list engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge
`define CLE_ASSERT_NEVER(lbl, cond, msg) \
  `CLE_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/cle_pkg.sv =====
// Package with sizes, codes and shared types of the circular list engine
`timescale 1ns / 1ps

package cle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_FWD  = 3'd6,
    CMD_READ_BWD  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADIDX = 3'd2,
    ST_FULL   = 3'd3,
    ST_APPEND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_UNLINK,
    S_READ
  } state_e;

  // Write ports and shared read address of the slot store
  typedef struct packed {
    logic             val_we;
    logic [IDX_W-1:0] val_addr;
    logic [VAL_W-1:0] val_data;
    logic             nxt_we;
    logic [IDX_W-1:0] nxt_addr;
    logic [IDX_W-1:0] nxt_data;
    logic             prv_we;
    logic [IDX_W-1:0] prv_addr;
    logic [IDX_W-1:0] prv_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_wr_t;

  // Registered read data of one slot
  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
  } mem_rd_t;

  // One result transaction
  typedef struct packed {
    logic             strobe;
    status_e          status;
    logic [VAL_W-1:0] element;
    logic             elem_valid;
    logic             last;
    logic [CNT_W-1:0] count;
  } res_t;

  // Lowest-numbered free slot
  function automatic logic [IDX_W-1:0] lowest_free(input logic [CAPACITY-1:0] free);
    logic [IDX_W-1:0] s;
    s = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free[i]) begin
        s = IDX_W'(i);
      end
    end
    return s;
  endfunction

endpackage

// ===== src/cle_store.sv =====
// Slot store: values, forward links and backward links with registered reads
`timescale 1ns / 1ps

module cle_store
  import cle_pkg::*;
(
  input  logic    clk_i,
  input  mem_wr_t wr_i,
  output mem_rd_t rd_o
);

  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [IDX_W-1:0] nxt_mem [CAPACITY];
  logic [IDX_W-1:0] prv_mem [CAPACITY];

  // Write and read slot values
  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_i.val_addr] <= wr_i.val_data;
    end
    rd_o.val <= val_mem[wr_i.rd_addr];
  end

  // Write and read forward links
  always_ff @(posedge clk_i) begin
    if (wr_i.nxt_we) begin
      nxt_mem[wr_i.nxt_addr] <= wr_i.nxt_data;
    end
    rd_o.nxt <= nxt_mem[wr_i.rd_addr];
  end

  // Write and read backward links
  always_ff @(posedge clk_i) begin
    if (wr_i.prv_we) begin
      prv_mem[wr_i.prv_addr] <= wr_i.prv_data;
    end
    rd_o.prv <= prv_mem[wr_i.rd_addr];
  end

endmodule

// ===== src/cle_ctrl.sv =====
// Command sequencer: decode, link walk, relink and list read
`timescale 1ns / 1ps

module cle_ctrl
  import cle_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0]              cmd_i,
  input  logic signed [7:0]       position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    busy_o,
  output mem_wr_t                 wr_o,
  input  mem_rd_t                 rd_i,
  output res_t                    res_o
);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [7:0]       pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic [IDX_W-1:0] new_q, new_d;
  logic [IDX_W-1:0] lp_q, lp_d;
  logic [IDX_W-1:0] lt_q, lt_d;
  status_e          st_q, st_d;
  logic             uph_q, uph_d;
  logic             upt_q, upt_d;
  res_t             res_q, res_d;

  logic [CMP_W-1:0] pos_ext;
  logic             pos_bad;
  logic             pos_zero;
  logic             is_empty;
  logic             is_full;
  logic             is_ins;
  logic             is_last;
  logic [IDX_W-1:0] free_slot;

  // Classify the held command against the current list
  assign pos_ext   = CMP_W'(pos_q[6:0]);
  assign pos_bad   = pos_q[7] || (pos_ext >= CMP_W'(count_q));
  assign pos_zero  = (pos_q == 8'd0);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(CAPACITY));
  assign is_ins    = (cmd_q inside {CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT});
  assign is_last   = (CNT_W'(step_q) == count_q - CNT_W'(1));
  assign free_slot = lowest_free(free_q);

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

  // State and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_INS_FRONT;
      pos_q   <= '0;
      val_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      free_q  <= '1;
      cur_q   <= '0;
      step_q  <= '0;
      tgt_q   <= '0;
      new_q   <= '0;
      lp_q    <= '0;
      lt_q    <= '0;
      st_q    <= ST_OK;
      uph_q   <= 1'b0;
      upt_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      pos_q   <= pos_d;
      val_q   <= val_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      free_q  <= free_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
      tgt_q   <= tgt_d;
      new_q   <= new_d;
      lp_q    <= lp_d;
      lt_q    <= lt_d;
      st_q    <= st_d;
      uph_q   <= uph_d;
      upt_q   <= upt_d;
      res_q   <= res_d;
    end
  end

  // Next state, store writes and result
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    pos_d   = pos_q;
    val_d   = val_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    free_d  = free_q;
    cur_d   = cur_q;
    step_d  = step_q;
    tgt_d   = tgt_q;
    new_d   = new_q;
    lp_d    = lp_q;
    lt_d    = lt_q;
    st_d    = st_q;
    uph_d   = uph_q;
    upt_d   = upt_q;
    wr_o    = '0;
    res_d   = '0;
    res_d.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_e'(cmd_i);
          pos_d   = position_i;
          val_d   = value_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        new_d  = free_slot;
        st_d   = ST_OK;
        uph_d  = 1'b0;
        upt_d  = 1'b0;
        step_d = '0;
        tgt_d  = '0;
        if (is_ins) begin
          if (is_full) begin
            res_d.strobe = 1'b1;
            res_d.status = ST_FULL;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else if (is_empty) begin
            // Lone entry links to itself
            lp_d    = free_slot;
            lt_d    = free_slot;
            uph_d   = 1'b1;
            upt_d   = 1'b1;
            st_d    = (cmd_q == CMD_INS_AT) ? ST_APPEND : ST_OK;
            state_d = S_LINK1;
          end else begin
            // Find the entry to insert before, starting at the head
            cur_d   = head_q;
            state_d = S_WALK;
            if (cmd_q == CMD_INS_FRONT || (cmd_q == CMD_INS_AT && pos_zero)) begin
              uph_d = 1'b1;
            end else if (cmd_q == CMD_INS_BACK) begin
              upt_d = 1'b1;
            end else if (pos_bad) begin
              upt_d = 1'b1;
              st_d  = ST_BADIDX;
            end else begin
              tgt_d = pos_ext[IDX_W-1:0];
            end
          end
        end else if (cmd_q == CMD_DEL_FRONT || cmd_q == CMD_DEL_BACK
                     || cmd_q == CMD_DEL_AT) begin
          if (is_empty) begin
            res_d.strobe = 1'b1;
            res_d.status = ST_EMPTY;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_WALK;
            if (cmd_q == CMD_DEL_FRONT || (cmd_q == CMD_DEL_AT && pos_zero)) begin
              cur_d = head_q;
            end else if (cmd_q == CMD_DEL_BACK) begin
              cur_d = tail_q;
            end else if (pos_bad) begin
              cur_d = tail_q;
              st_d  = ST_BADIDX;
            end else begin
              cur_d = head_q;
              tgt_d = pos_ext[IDX_W-1:0];
            end
          end
        end else begin
          if (is_empty) begin
            res_d.strobe = 1'b1;
            res_d.status = ST_EMPTY;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cur_d   = (cmd_q == CMD_READ_FWD) ? head_q : tail_q;
            state_d = S_READ;
          end
        end
      end

      S_WALK: begin
        // Step one link per cycle until the target index
        if (step_q == tgt_q) begin
          lp_d = rd_i.prv;
          if (is_ins) begin
            lt_d    = cur_q;
            state_d = S_LINK1;
          end else begin
            lt_d    = rd_i.nxt;
            state_d = S_UNLINK;
          end
        end else begin
          cur_d  = rd_i.nxt;
          step_d = step_q + IDX_W'(1);
        end
      end

      S_LINK1: begin
        // Store the value and hook the new slot after its predecessor
        wr_o.val_we   = 1'b1;
        wr_o.val_addr = new_q;
        wr_o.val_data = val_q;
        wr_o.nxt_we   = 1'b1;
        wr_o.nxt_addr = lp_q;
        wr_o.nxt_data = new_q;
        wr_o.prv_we   = 1'b1;
        wr_o.prv_addr = new_q;
        wr_o.prv_data = lp_q;
        state_d       = S_LINK2;
      end

      S_LINK2: begin
        // Hook the new slot before its successor and commit
        wr_o.nxt_we   = 1'b1;
        wr_o.nxt_addr = new_q;
        wr_o.nxt_data = lt_q;
        wr_o.prv_we   = 1'b1;
        wr_o.prv_addr = lt_q;
        wr_o.prv_data = new_q;
        if (uph_q) begin
          head_d = new_q;
        end
        if (upt_q) begin
          tail_d = new_q;
        end
        count_d        = count_q + CNT_W'(1);
        free_d[new_q]  = 1'b0;
        res_d.strobe   = 1'b1;
        res_d.status   = st_q;
        res_d.last     = 1'b1;
        state_d        = S_IDLE;
      end

      S_UNLINK: begin
        // Bridge the neighbors of the removed slot
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          wr_o.nxt_we   = 1'b1;
          wr_o.nxt_addr = lp_q;
          wr_o.nxt_data = lt_q;
          wr_o.prv_we   = 1'b1;
          wr_o.prv_addr = lt_q;
          wr_o.prv_data = lp_q;
          if (cur_q == head_q) begin
            head_d = lt_q;
          end
          if (cur_q == tail_q) begin
            tail_d = lp_q;
          end
        end
        count_d       = count_q - CNT_W'(1);
        free_d[cur_q] = 1'b1;
        res_d.strobe  = 1'b1;
        res_d.status  = st_q;
        res_d.last    = 1'b1;
        state_d       = S_IDLE;
      end

      S_READ: begin
        // Emit one entry per cycle and follow the link
        res_d.strobe     = 1'b1;
        res_d.element    = rd_i.val;
        res_d.elem_valid = 1'b1;
        res_d.last       = is_last;
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          cur_d  = (cmd_q == CMD_READ_FWD) ? rd_i.nxt : rd_i.prv;
          step_d = step_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count  = count_d;
    wr_o.rd_addr = cur_d;
  end

endmodule

// ===== src/circular_list_engine.sv =====
// An insert passes decode, a link walk from the head and two relink states; into an empty list it
// skips the walk. A delete passes decode, a link walk and an unlink state.
// A read emits one result per cycle after decode; a dropped insert, an empty delete or an empty
// read reports from decode. The next command can be taken while the result is shown.
// The link walk steps one slot per cycle through the registered store read.
// Results cannot stall. Reset empties the list and frees all slots; slot storage is not cleared.
`timescale 1ns / 1ps

module circular_list_engine
  import cle_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              cmd_i,
  input  logic signed [7:0]       position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic signed [VAL_W-1:0] element_o,
  output logic                    element_valid_o,
  output logic                    last_o,
  output logic [CNT_W-1:0]        count_o
);

  mem_wr_t wr;
  mem_rd_t rd;
  res_t    res;

  // Sequencer
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .value_i    (value_i),
    .busy_o     (busy),
    .wr_o       (wr),
    .rd_i       (rd),
    .res_o      (res)
  );

  // Slot storage
  cle_store u_store (
    .clk_i (clk_i),
    .wr_i  (wr),
    .rd_o  (rd)
  );

  // Drive the result transaction
  assign done_o          = res.strobe;
  assign status_o        = res.status;
  assign element_o       = res.element;
  assign element_valid_o = res.elem_valid;
  assign last_o          = res.last;
  assign count_o         = res.count;

endmodule

// ===== src/cle_checker.sv =====
// Port-level checker for the circular list engine, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cle_checker
  import cle_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [2:0]              status_o,
  input logic                    element_valid_o,
  input logic                    last_o,
  input logic [CNT_W-1:0]        count_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // Engine is busy in the cycle after an accepted command
  `CLE_ASSERT(a_busy_after_start, start && !busy |=> busy, "engine idle after accepted command")

  // Entry count never exceeds the slot count
  `CLE_ASSERT(a_count_bound, done_o |-> count_o <= FULL_CNT, "count above capacity")

  // A result without an element closes its command
  `CLE_ASSERT(a_single_last, done_o && !element_valid_o |-> last_o, "non-read result not last")

  // A dropped insert reports a full list
  `CLE_ASSERT(a_full_count, done_o && status_o == ST_FULL |-> count_o == FULL_CNT, "full with room")

  // Read elements always carry ok status
  `CLE_ASSERT_NEVER(a_elem_status, done_o && element_valid_o && status_o != ST_OK, "read not ok")

endmodule

bind circular_list_engine cle_checker u_cle_checker (.*);
